FILE: sv/mips_ex_pkg.sv
package mips_ex_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CodeW = 6;
  localparam int unsigned ShamtW = 5;

  // R-type function codes.
  localparam logic [CodeW-1:0] FN_SLL   = 6'h00;
  localparam logic [CodeW-1:0] FN_SRL   = 6'h02;
  localparam logic [CodeW-1:0] FN_SRA   = 6'h03;
  localparam logic [CodeW-1:0] FN_MFHI  = 6'h10;
  localparam logic [CodeW-1:0] FN_MFLO  = 6'h12;
  localparam logic [CodeW-1:0] FN_MULT  = 6'h18;
  localparam logic [CodeW-1:0] FN_MULTU = 6'h19;
  localparam logic [CodeW-1:0] FN_ADD   = 6'h20;
  localparam logic [CodeW-1:0] FN_ADDU  = 6'h21;
  localparam logic [CodeW-1:0] FN_SUB   = 6'h22;
  localparam logic [CodeW-1:0] FN_AND   = 6'h24;
  localparam logic [CodeW-1:0] FN_OR    = 6'h25;
  localparam logic [CodeW-1:0] FN_XOR   = 6'h26;
  localparam logic [CodeW-1:0] FN_NOR   = 6'h27;
  localparam logic [CodeW-1:0] FN_NAND  = 6'h28;
  localparam logic [CodeW-1:0] FN_SLT   = 6'h2A;

  // Primary opcodes.
  localparam logic [CodeW-1:0] OP_JAL   = 6'h03;
  localparam logic [CodeW-1:0] OP_ADDI  = 6'h08;
  localparam logic [CodeW-1:0] OP_ADDIU = 6'h09;
  localparam logic [CodeW-1:0] OP_SLTI  = 6'h0A;
  localparam logic [CodeW-1:0] OP_ANDI  = 6'h0C;
  localparam logic [CodeW-1:0] OP_ORI   = 6'h0D;
  localparam logic [CodeW-1:0] OP_NORI  = 6'h0E;
  localparam logic [CodeW-1:0] OP_LUI   = 6'h0F;
  localparam logic [CodeW-1:0] OP_LB    = 6'h20;
  localparam logic [CodeW-1:0] OP_LH    = 6'h21;
  localparam logic [CodeW-1:0] OP_LW    = 6'h23;
  localparam logic [CodeW-1:0] OP_LBU   = 6'h24;
  localparam logic [CodeW-1:0] OP_LHU   = 6'h25;
  localparam logic [CodeW-1:0] OP_SB    = 6'h28;
  localparam logic [CodeW-1:0] OP_SH    = 6'h29;
  localparam logic [CodeW-1:0] OP_SW    = 6'h2B;

  localparam logic [DataW-1:0] PcStep = 32'd4;

  typedef struct packed {
    logic mul_en;
    logic mul_signed;
    logic read_clr;
  } hilo_ctrl_t;

  typedef struct packed {
    logic [DataW-1:0] hi;
    logic [DataW-1:0] lo;
    logic             unread;
  } hilo_state_t;

endpackage

FILE: sv/mips_ex_hilo.sv
module mips_ex_hilo (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  mips_ex_pkg::hilo_ctrl_t               ctrl_i,
  input  logic [mips_ex_pkg::DataW-1:0]         rs_value_i,
  input  logic [mips_ex_pkg::DataW-1:0]         rt_value_i,
  output mips_ex_pkg::hilo_state_t              state_o
);

  localparam int unsigned OpW = mips_ex_pkg::DataW + 1;
  localparam int unsigned ProdW = 2 * mips_ex_pkg::DataW;

  logic signed [OpW-1:0]   mul_a, mul_b;
  logic signed [2*OpW-1:0] prod_full;
  logic [ProdW-1:0]        prod;
  logic [mips_ex_pkg::DataW-1:0] hi_q, hi_d, lo_q, lo_d;
  logic unread_q, unread_d;

  // One 33x33 signed multiplier covers both forms: the extra top bit carries
  // the sign for mult and a zero for multu.
  assign mul_a = $signed({ctrl_i.mul_signed & rs_value_i[mips_ex_pkg::DataW-1], rs_value_i});
  assign mul_b = $signed({ctrl_i.mul_signed & rt_value_i[mips_ex_pkg::DataW-1], rt_value_i});
  assign prod_full = mul_a * mul_b;
  assign prod = prod_full[ProdW-1:0];

  always_comb begin
    hi_d = hi_q;
    lo_d = lo_q;
    unread_d = unread_q;
    if (step_i && ctrl_i.mul_en) begin
      hi_d = prod[ProdW-1:mips_ex_pkg::DataW];
      lo_d = prod[mips_ex_pkg::DataW-1:0];
      unread_d = 1'b1;
    end else if (step_i && ctrl_i.read_clr) begin
      unread_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
      unread_q <= 1'b0;
    end else begin
      hi_q <= hi_d;
      lo_q <= lo_d;
      unread_q <= unread_d;
    end
  end

  assign state_o = '{hi: hi_q, lo: lo_q, unread: unread_q};

endmodule

FILE: sv/mips_ex_alu.sv
module mips_ex_alu (
  input  logic                                  is_r_type_i,
  input  logic [mips_ex_pkg::CodeW-1:0]         opcode_i,
  input  logic [mips_ex_pkg::CodeW-1:0]         func_i,
  input  logic [mips_ex_pkg::DataW-1:0]         rs_value_i,
  input  logic [mips_ex_pkg::DataW-1:0]         rt_value_i,
  input  logic [mips_ex_pkg::DataW-1:0]         imm_i,
  input  logic [mips_ex_pkg::DataW-1:0]         pc_i,
  input  mips_ex_pkg::hilo_state_t              hilo_i,
  output mips_ex_pkg::hilo_ctrl_t               ctrl_o,
  output logic [mips_ex_pkg::DataW-1:0]         result_o,
  output logic                                  overflow_o,
  output logic                                  overwrite_hilo_o
);

  localparam int unsigned W = mips_ex_pkg::DataW;
  localparam int unsigned HalfW = W / 2;

  logic [W-1:0] a, b, im, z16;
  logic [mips_ex_pkg::ShamtW-1:0] sh;
  logic [W-1:0] sum_ab, diff_ab, sum_ai;
  logic ovf_ab, ovf_sub, ovf_ai;

  assign a = rs_value_i;
  assign b = rt_value_i;
  assign im = imm_i;
  assign sh = imm_i[mips_ex_pkg::ShamtW-1:0];
  assign z16 = {{(W-HalfW){1'b0}}, imm_i[HalfW-1:0]};

  assign sum_ab = a + b;
  assign diff_ab = a - b;
  assign sum_ai = a + im;
  assign ovf_ab = ~(a[W-1] ^ b[W-1]) & (a[W-1] ^ sum_ab[W-1]);
  assign ovf_sub = (a[W-1] ^ b[W-1]) & (a[W-1] ^ diff_ab[W-1]);
  assign ovf_ai = ~(a[W-1] ^ im[W-1]) & (a[W-1] ^ sum_ai[W-1]);

  always_comb begin
    result_o = '0;
    overflow_o = 1'b0;
    overwrite_hilo_o = 1'b0;
    ctrl_o = '0;
    if (is_r_type_i) begin
      case (func_i)
        mips_ex_pkg::FN_ADD: begin
          result_o = sum_ab;
          overflow_o = ovf_ab;
        end
        mips_ex_pkg::FN_ADDU: result_o = sum_ab;
        mips_ex_pkg::FN_SUB: begin
          result_o = diff_ab;
          overflow_o = ovf_sub;
        end
        mips_ex_pkg::FN_AND:  result_o = a & b;
        mips_ex_pkg::FN_OR:   result_o = a | b;
        mips_ex_pkg::FN_XOR:  result_o = a ^ b;
        mips_ex_pkg::FN_NOR:  result_o = ~(a | b);
        mips_ex_pkg::FN_NAND: result_o = ~(a & b);
        mips_ex_pkg::FN_SLT:  result_o = {{(W-1){1'b0}}, $signed(a) < $signed(b)};
        mips_ex_pkg::FN_SLL:  result_o = b << sh;
        mips_ex_pkg::FN_SRL:  result_o = b >> sh;
        mips_ex_pkg::FN_SRA:  result_o = $unsigned($signed(b) >>> sh);
        mips_ex_pkg::FN_MULT: begin
          ctrl_o.mul_en = 1'b1;
          ctrl_o.mul_signed = 1'b1;
          overwrite_hilo_o = hilo_i.unread;
        end
        mips_ex_pkg::FN_MULTU: begin
          ctrl_o.mul_en = 1'b1;
          overwrite_hilo_o = hilo_i.unread;
        end
        mips_ex_pkg::FN_MFHI: begin
          result_o = hilo_i.hi;
          ctrl_o.read_clr = 1'b1;
        end
        mips_ex_pkg::FN_MFLO: begin
          result_o = hilo_i.lo;
          ctrl_o.read_clr = 1'b1;
        end
        default: result_o = '0;
      endcase
    end else begin
      case (opcode_i)
        mips_ex_pkg::OP_ADDI,
        mips_ex_pkg::OP_LB, mips_ex_pkg::OP_LH, mips_ex_pkg::OP_LW,
        mips_ex_pkg::OP_LBU, mips_ex_pkg::OP_LHU, mips_ex_pkg::OP_SB,
        mips_ex_pkg::OP_SH, mips_ex_pkg::OP_SW: begin
          result_o = sum_ai;
          overflow_o = ovf_ai;
        end
        mips_ex_pkg::OP_ADDIU: result_o = sum_ai;
        mips_ex_pkg::OP_LUI:   result_o = {im[HalfW-1:0], {HalfW{1'b0}}};
        mips_ex_pkg::OP_ANDI:  result_o = a & z16;
        mips_ex_pkg::OP_ORI:   result_o = a | z16;
        mips_ex_pkg::OP_NORI:  result_o = ~(a | z16);
        mips_ex_pkg::OP_SLTI:  result_o = {{(W-1){1'b0}}, $signed(a) < $signed(im)};
        mips_ex_pkg::OP_JAL:   result_o = pc_i + mips_ex_pkg::PcStep;
        default: result_o = '0;
      endcase
    end
  end

endmodule

FILE: sv/mips_execute_alu_hilo_core.sv
// Execute stage with ALU and HI/LO multiply unit.
// The result passes through the input register and then the result register before it is valid;
// a stalled result holds both registers.
// Throughput: 1 item per cycle while out_stall_i is low; the 33x33 multiplier feeds
// the HI/LO registers directly, so mfhi/mflo right after a multiply see the new product.
// Reset: asynchronous, active low; clears valids, HI, LO and the unread flag.
module mips_execute_alu_hilo_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          is_r_type_i,
  input  logic [mips_ex_pkg::CodeW-1:0] opcode_i,
  input  logic [mips_ex_pkg::CodeW-1:0] func_i,
  input  logic [mips_ex_pkg::DataW-1:0] rs_value_i,
  input  logic [mips_ex_pkg::DataW-1:0] rt_value_i,
  input  logic [mips_ex_pkg::DataW-1:0] imm_i,
  input  logic [mips_ex_pkg::DataW-1:0] pc_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mips_ex_pkg::DataW-1:0] result_o,
  output logic                          overflow_o,
  output logic                          overwrite_hilo_o
);

  logic in_valid_q;
  logic is_r_type_q;
  logic [mips_ex_pkg::CodeW-1:0] opcode_q, func_q;
  logic [mips_ex_pkg::DataW-1:0] rs_value_q, rt_value_q, imm_q, pc_q;

  logic out_valid_q;
  logic [mips_ex_pkg::DataW-1:0] result_q, result_d;
  logic overflow_q, overflow_d, overwrite_q, overwrite_d;

  logic out_load, step, in_load;
  mips_ex_pkg::hilo_ctrl_t  hilo_ctrl;
  mips_ex_pkg::hilo_state_t hilo_state;

  // The result register loads when it is empty or its item is being taken.
  assign out_load = !out_valid_q || !out_stall_i;
  assign step = in_valid_q && out_load;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      is_r_type_q <= is_r_type_i;
      opcode_q <= opcode_i;
      func_q <= func_i;
      rs_value_q <= rs_value_i;
      rt_value_q <= rt_value_i;
      imm_q <= imm_i;
      pc_q <= pc_i;
    end
    if (step) begin
      result_q <= result_d;
      overflow_q <= overflow_d;
      overwrite_q <= overwrite_d;
    end
  end

  mips_ex_alu u_alu (
    .is_r_type_i      (is_r_type_q),
    .opcode_i         (opcode_q),
    .func_i           (func_q),
    .rs_value_i       (rs_value_q),
    .rt_value_i       (rt_value_q),
    .imm_i            (imm_q),
    .pc_i             (pc_q),
    .hilo_i           (hilo_state),
    .ctrl_o           (hilo_ctrl),
    .result_o         (result_d),
    .overflow_o       (overflow_d),
    .overwrite_hilo_o (overwrite_d)
  );

  mips_ex_hilo u_hilo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .ctrl_i     (hilo_ctrl),
    .rs_value_i (rs_value_q),
    .rt_value_i (rt_value_q),
    .state_o    (hilo_state)
  );

  assign out_valid_o = out_valid_q;
  assign result_o = result_q;
  assign overflow_o = overflow_q;
  assign overwrite_hilo_o = overwrite_q;

endmodule
